// ----- hw/rtl/rbs_pkg.sv -----
package rbs_pkg;

    // Field widths are those of the external interface.
    localparam int COORD_BITS = 32;
    localparam int TIME_BITS  = 31;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
        coord_t inv_dir_x;
        coord_t inv_dir_y;
        coord_t inv_dir_z;
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_min_z;
        coord_t box_max_x;
        coord_t box_max_y;
        coord_t box_max_z;
    } rbs_item_t;

    typedef struct packed {
        logic                 hit;
        logic [TIME_BITS-1:0] hit_time;
    } rbs_result_t;

endpackage

// ----- hw/rtl/ray_box_slab_intersect.sv -----
// Ray / axis-aligned box slab test, Q(COORD_BITS-FRAC_BITS).FRAC_BITS fixed point.
// An accepted item passes through the six register stages before result_valid rises.
// Throughput: one transaction per cycle when the output is not stalled; the six register stages
// each hold one item and stall independently, so bubbles are squeezed out under backpressure.
// Reset (rst_n, async, active low) clears all stage valid bits; data regs are not reset.
module ray_box_slab_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  rbs_pkg::rbs_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output rbs_pkg::rbs_result_t result
);
    import rbs_pkg::*;

    // Pipeline map:
    //   stage 0: corner - origin differences (exact, one extra bit)
    //   stage 1: full signed products
    //   stage 2: shift toward zero by FRAC_BITS, saturate to coordinate range
    //   stage 3: per-axis near/far ordering
    //   stage 4: entry = max of near, exit = min of far
    //   stage 5: hit decision and reported time
    localparam int STAGES = 6;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = DIFF_W + COORD_BITS;

    localparam logic [PROD_W-1:0] ONE_P      = PROD_W'(1);
    localparam logic [PROD_W-1:0] ROUND_BIAS = (ONE_P << FRAC_BITS) - ONE_P;
    localparam coord_t            T_MAX      = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t            T_MIN      = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam coord_t            ZERO       = '0;

    // ------------------------------------------------------------------
    // Stage handshake: a stage may load when it is empty or its contents
    // move on in the same cycle.
    // ------------------------------------------------------------------
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] stage_ready;

    always_comb
    begin
        stage_ready[STAGES-1] = !valid_reg[STAGES-1] || result_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign item_ready = stage_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[0])
            begin
                valid_reg[0] <= item_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: slab plane offsets. Index [axis][0] uses the min corner,
    // [axis][1] the max corner.
    // ------------------------------------------------------------------
    coord_t                    origin   [3];
    coord_t                    inv_dir  [3];
    coord_t                    box_min  [3];
    coord_t                    box_max  [3];
    logic signed [DIFF_W-1:0]  diff_next [3][2];
    logic signed [DIFF_W-1:0]  diff_reg  [3][2];
    coord_t                    inv_reg   [3];

    always_comb
    begin
        origin[0]  = item.origin_x;
        origin[1]  = item.origin_y;
        origin[2]  = item.origin_z;
        inv_dir[0] = item.inv_dir_x;
        inv_dir[1] = item.inv_dir_y;
        inv_dir[2] = item.inv_dir_z;
        box_min[0] = item.box_min_x;
        box_min[1] = item.box_min_y;
        box_min[2] = item.box_min_z;
        box_max[0] = item.box_max_x;
        box_max[1] = item.box_max_y;
        box_max[2] = item.box_max_z;
        for (int a = 0; a < 3; a++)
        begin
            diff_next[a][0] = DIFF_W'(box_min[a]) - DIFF_W'(origin[a]);
            diff_next[a][1] = DIFF_W'(box_max[a]) - DIFF_W'(origin[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            for (int a = 0; a < 3; a++)
            begin
                diff_reg[a][0] <= diff_next[a][0];
                diff_reg[a][1] <= diff_next[a][1];
                inv_reg[a]     <= inv_dir[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: one 33x32 signed multiply per slab plane, exact.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod_next [3][2];
    logic signed [PROD_W-1:0] prod_reg  [3][2];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            prod_next[a][0] = PROD_W'(diff_reg[a][0]) * PROD_W'(inv_reg[a]);
            prod_next[a][1] = PROD_W'(diff_reg[a][1]) * PROD_W'(inv_reg[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[1])
        begin
            prod_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: drop fraction toward zero (bias negatives before the
    // arithmetic shift), then clamp to the coordinate range.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] biased  [3][2];
    logic signed [PROD_W-1:0] shifted [3][2];
    coord_t                   slab_next [3][2];
    coord_t                   slab_reg  [3][2];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                biased[a][j]  = prod_reg[a][j]
                              + (prod_reg[a][j][PROD_W-1] ? ROUND_BIAS : '0);
                shifted[a][j] = biased[a][j] >>> FRAC_BITS;
                // In range when the coordinate sign bit and all bits above it agree.
                if ((&shifted[a][j][PROD_W-1:COORD_BITS-1])
                    || !(|shifted[a][j][PROD_W-1:COORD_BITS-1]))
                begin
                    slab_next[a][j] = shifted[a][j][COORD_BITS-1:0];
                end
                else
                begin
                    slab_next[a][j] = shifted[a][j][PROD_W-1] ? T_MIN : T_MAX;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[2])
        begin
            slab_reg <= slab_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: order each axis pair, so swapped corners are harmless.
    // ------------------------------------------------------------------
    coord_t near_reg [3];
    coord_t far_reg  [3];

    always_ff @(posedge clk)
    begin
        if (stage_ready[3])
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (slab_reg[a][0] < slab_reg[a][1])
                begin
                    near_reg[a] <= slab_reg[a][0];
                    far_reg[a]  <= slab_reg[a][1];
                end
                else
                begin
                    near_reg[a] <= slab_reg[a][1];
                    far_reg[a]  <= slab_reg[a][0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: entry is the latest near plane, exit the earliest far plane.
    // ------------------------------------------------------------------
    coord_t entry_xy;
    coord_t exit_xy;
    coord_t entry_next;
    coord_t exit_next;
    coord_t entry_reg;
    coord_t exit_reg;

    always_comb
    begin
        entry_xy   = (near_reg[1] > near_reg[0]) ? near_reg[1] : near_reg[0];
        entry_next = (near_reg[2] > entry_xy) ? near_reg[2] : entry_xy;
        exit_xy    = (far_reg[1] < far_reg[0]) ? far_reg[1] : far_reg[0];
        exit_next  = (far_reg[2] < exit_xy) ? far_reg[2] : exit_xy;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[4])
        begin
            entry_reg <= entry_next;
            exit_reg  <= exit_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: hit when the interval is non-empty and ends ahead of the
    // origin. A negative entry means the origin is inside: report exit.
    // Both candidates are non-negative here, so the low bits are the time.
    // ------------------------------------------------------------------
    logic        hit_next;
    coord_t      time_sel;
    rbs_result_t out_next;
    rbs_result_t out_reg;

    always_comb
    begin
        hit_next          = (exit_reg > ZERO) && (exit_reg >= entry_reg);
        time_sel          = (entry_reg >= ZERO) ? entry_reg : exit_reg;
        out_next.hit      = hit_next;
        out_next.hit_time = hit_next ? time_sel[TIME_BITS-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[5])
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = valid_reg[STAGES-1];
    assign result       = out_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_miss_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.hit |-> result.hit_time == '0)
        else $error("miss reported with nonzero time");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !result_ready |-> !item_ready)
        else $error("item taken while pipeline full and stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> valid_reg[0])
        else $error("accepted transaction lost at stage 0");

    a_last_move: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STAGES-2] && stage_ready[STAGES-1] |=> result_valid)
        else $error("transaction lost entering output stage");

    a_empty_interval: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] && stage_ready[5] && (entry_reg > exit_reg) |=> !out_reg.hit)
        else $error("hit reported on empty interval");

endmodule

// ----- dv/tb_ray_box_slab_intersect.sv -----
`timescale 1ns / 1ps

module tb_ray_box_slab_intersect;

    import rbs_pkg::*;

    localparam int     FRAC_BITS = 16;
    localparam longint ONE       = 64'sd65536;           // 1.0 in Q16.16
    localparam coord_t CMAX      = 32'sh7FFF_FFFF;
    localparam coord_t CMIN      = 32'sh8000_0000;
    localparam int     IDLE_PCT  = 29;                   // idle chance per cycle, each side
    localparam int     RANDOM_ITEMS = 1200;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // DUT ports; every input has a known value from time zero
    logic        item_valid   = 1'b0;
    logic        item_ready;
    rbs_item_t   item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    rbs_result_t result;

    ray_box_slab_intersect #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    // Rays waiting to be sent, and hit results owed by the DUT, oldest first
    rbs_item_t   pending_rays[$];
    rbs_result_t owed_hits[$];

    int  mismatches     = 0;
    int  rays_accepted  = 0;
    int  hits_checked   = 0;
    bit  ray_taken      = 1'b0;   // set at posedge when an item transaction completed
    int  stall_left     = 0;
    bit  stall_done     = 1'b0;

    // No idling on either side while this window of transactions goes through
    wire quiet = (rays_accepted >= 500) && (rays_accepted < 750);

    //------------------------------------------------------------------
    // Slab-time arithmetic: exact (corner - origin) * inv, shifted right
    // by FRAC_BITS toward zero, saturated to the signed 32-bit range.
    // Done on magnitudes so truncation is toward zero for negative times.
    //------------------------------------------------------------------
    function automatic longint slab_time_q(longint diff, longint inv);
        logic        neg;
        logic [63:0] mag_d;
        logic [63:0] mag_i;
        logic [63:0] prod;
        logic [63:0] quo;
        neg   = (diff < 0) != (inv < 0);
        mag_d = (diff < 0) ? -diff : diff;
        mag_i = (inv < 0) ? -inv : inv;
        prod  = mag_d * mag_i;            // at most 2^32 * 2^31, no overflow
        quo   = prod >> FRAC_BITS;
        if (neg)
            return (quo > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(quo);
        else
            return (quo > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(quo);
    endfunction

    // Full ray/box test for one item: entry = max of per-axis near times,
    // exit = min of per-axis far times; hit when exit > 0 and exit >= entry.
    function automatic rbs_result_t slab_hit_predict(rbs_item_t it);
        coord_t      org[3];
        coord_t      inv[3];
        coord_t      lo_c[3];
        coord_t      hi_c[3];
        longint      t_a;
        longint      t_b;
        longint      t_near;
        longint      t_far;
        longint      t_entry;
        longint      t_exit;
        logic [63:0] t_sel;
        rbs_result_t r;
        org  = '{it.origin_x, it.origin_y, it.origin_z};
        inv  = '{it.inv_dir_x, it.inv_dir_y, it.inv_dir_z};
        lo_c = '{it.box_min_x, it.box_min_y, it.box_min_z};
        hi_c = '{it.box_max_x, it.box_max_y, it.box_max_z};
        t_entry = 0;
        t_exit  = 0;
        for (int a = 0; a < 3; a++)
        begin
            t_a = slab_time_q(longint'(lo_c[a]) - longint'(org[a]), longint'(inv[a]));
            t_b = slab_time_q(longint'(hi_c[a]) - longint'(org[a]), longint'(inv[a]));
            // min/max of the pair, so swapped corners are harmless
            t_near = (t_a < t_b) ? t_a : t_b;
            t_far  = (t_a < t_b) ? t_b : t_a;
            if (a == 0 || t_near > t_entry)
                t_entry = t_near;
            if (a == 0 || t_far < t_exit)
                t_exit = t_far;
        end
        r = '0;
        if (t_exit > 0 && t_exit >= t_entry)
        begin
            // report the entry time, or the exit time when the origin is inside the box
            // (at 32-bit coordinates the time never exceeds 31 bits)
            t_sel      = (t_entry >= 0) ? t_entry : t_exit;
            r.hit      = 1'b1;
            r.hit_time = t_sel[TIME_BITS-1:0];
        end
        return r;
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------
    function automatic rbs_item_t ray_item(longint ox, longint oy, longint oz,
                                           longint ix, longint iy, longint iz,
                                           longint nx, longint ny, longint nz,
                                           longint xx, longint xy, longint xz);
        rbs_item_t it;
        it.origin_x  = coord_t'(ox);
        it.origin_y  = coord_t'(oy);
        it.origin_z  = coord_t'(oz);
        it.inv_dir_x = coord_t'(ix);
        it.inv_dir_y = coord_t'(iy);
        it.inv_dir_z = coord_t'(iz);
        it.box_min_x = coord_t'(nx);
        it.box_min_y = coord_t'(ny);
        it.box_min_z = coord_t'(nz);
        it.box_max_x = coord_t'(xx);
        it.box_max_y = coord_t'(xy);
        it.box_max_z = coord_t'(xz);
        return it;
    endfunction

    // Well-formed scene: a box of moderate size and a ray aimed at a point
    // inside it, either from a random origin or starting inside. Some axes get a
    // zero direction (saturated inverse), some boxes swapped corners.
    function automatic rbs_item_t aimed_ray(bit from_inside);
        longint ctr;
        longint half;
        longint tgt;
        longint org;
        longint d;
        longint recip;
        coord_t o[3];
        coord_t iv[3];
        coord_t bl[3];
        coord_t bh[3];
        for (int a = 0; a < 3; a++)
        begin
            ctr  = longint'($urandom_range(0, 128 * ONE)) - 64 * ONE;
            half = longint'($urandom_range(ONE / 16, 32 * ONE));
            tgt  = ctr + longint'($urandom_range(0, 2 * half)) - half;
            if (from_inside)
            begin
                org = tgt;
                tgt = longint'($urandom_range(0, 256 * ONE)) - 128 * ONE;
            end
            else
                org = longint'($urandom_range(0, 256 * ONE)) - 128 * ONE;
            d = (tgt - org) >>> $urandom_range(0, 6);
            if ($urandom_range(0, 9) == 0)
                d = 0;
            if (d == 0)
                recip = $urandom_range(0, 1) ? CMAX : CMIN;
            else
            begin
                recip = (64'sd1 <<< 32) / d;
                if (recip > CMAX)
                    recip = CMAX;
                else if (recip < CMIN)
                    recip = CMIN;
            end
            o[a]  = coord_t'(org);
            iv[a] = coord_t'(recip);
            if ($urandom_range(0, 3) == 0)
            begin
                bl[a] = coord_t'(ctr + half);
                bh[a] = coord_t'(ctr - half);
            end
            else
            begin
                bl[a] = coord_t'(ctr - half);
                bh[a] = coord_t'(ctr + half);
            end
        end
        return ray_item(o[0], o[1], o[2], iv[0], iv[1], iv[2],
                        bl[0], bl[1], bl[2], bh[0], bh[1], bh[2]);
    endfunction

    // Any field value, fully random or weighted toward the corners of the range
    function automatic rbs_item_t edgy_ray(bit full_random);
        logic [12*COORD_BITS-1:0] raw;
        coord_t                   v;
        for (int k = 0; k < 12; k++)
        begin
            if (full_random)
                v = $urandom;
            else
                case ($urandom_range(0, 5))
                    0:       v = CMIN;
                    1:       v = CMAX;
                    2:       v = '0;
                    3:       v = -1;
                    4:       v = 1;
                    default: v = $urandom;
                endcase
            raw[k*COORD_BITS +: COORD_BITS] = v;
        end
        return rbs_item_t'(raw);
    endfunction

    task automatic flag_mismatch(string what);
        if (mismatches < 200)
            $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    //------------------------------------------------------------------
    // Driver: launches the next ray at the falling edge once the previous
    // item transaction has completed; valid holds until accepted.
    //------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || ray_taken))
        begin
            if (pending_rays.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                item       <= pending_rays.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Receiver: random backpressure, plus one long hold-off that lets the
    // pipeline fill and push back on the input side.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left   = stall_left - 1;
            result_ready <= 1'b0;
        end
        else if (!stall_done && hits_checked >= 900)
        begin
            stall_done   = 1'b1;
            stall_left   = 60;
            result_ready <= 1'b0;
        end
        else
            result_ready <= rst_n && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
    end

    //------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge. Accepted rays
    // queue a predicted result; each result transaction is checked
    // against the oldest one.
    //------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        rbs_result_t want;
        if (!rst_n)
            ray_taken = 1'b0;
        else
        begin
            ray_taken = item_valid && item_ready;
            if (ray_taken)
            begin
                owed_hits.push_back(slab_hit_predict(item));
                rays_accepted++;
            end
            if (result_valid && result_ready)
            begin
                if (owed_hits.size() == 0)
                    flag_mismatch($sformatf("result #%0d with nothing owed: hit=%0b time=%0h",
                                            hits_checked, result.hit, result.hit_time));
                else
                begin
                    want = owed_hits.pop_front();
                    if (result.hit !== want.hit)
                        flag_mismatch($sformatf("result #%0d hit: got %0b want %0b",
                                                hits_checked, result.hit, want.hit));
                    if (result.hit_time !== want.hit_time)
                        flag_mismatch($sformatf("result #%0d hit_time: got %0h want %0h",
                                                hits_checked, result.hit_time,
                                                want.hit_time));
                end
                hits_checked++;
            end
        end
    end

    //------------------------------------------------------------------
    // Sequence: reset, directed rays, full drain, random rays, drain, verdict
    //------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Unit box [-1,1]^3 unless noted; ray mostly along +x
        // hit from outside at t = 4
        pending_rays.push_back(ray_item(-5*ONE, 0, 0, ONE, CMAX, CMAX,
                                        -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // origin inside: exit time reported
        pending_rays.push_back(ray_item(0, 0, 0, ONE, CMAX, CMAX,
                                        -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // box behind the ray: miss
        pending_rays.push_back(ray_item(5*ONE, 0, 0, ONE, CMAX, CMAX,
                                        -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // negative direction toward the box
        pending_rays.push_back(ray_item(5*ONE, 0, 0, -ONE, CMAX, CMAX,
                                        -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // parallel to y slabs but outside them: miss
        pending_rays.push_back(ray_item(-5*ONE, 3*ONE, 0, ONE, CMAX, CMAX,
                                        -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // zero y direction lying on the max y plane, negative saturated inverse
        pending_rays.push_back(ray_item(-5*ONE, ONE, 0, ONE, CMIN, CMAX,
                                        -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // zero y direction lying on the min y plane
        pending_rays.push_back(ray_item(-5*ONE, -ONE, 0, ONE, CMAX, CMAX,
                                        -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // swapped corners on every axis
        pending_rays.push_back(ray_item(-5*ONE, 0, 0, ONE, CMAX, CMAX,
                                        ONE, ONE, ONE, -ONE, -ONE, -ONE));
        // grazing an edge: entry equals exit
        pending_rays.push_back(ray_item(-3*ONE, -ONE, 0, ONE, ONE, CMAX,
                                        -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // origin on the entry face: hit at time zero
        pending_rays.push_back(ray_item(-ONE, 0, 0, ONE, CMAX, CMAX,
                                        -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // origin on the exit face: exit is zero, miss
        pending_rays.push_back(ray_item(ONE, 0, 0, ONE, CMAX, CMAX,
                                        -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // inside with every inverse saturated: time saturates
        pending_rays.push_back(ray_item(0, 0, 0, CMAX, CMAX, CMAX,
                                        -ONE, -ONE, -ONE, ONE, ONE, ONE));
        // huge differences times huge inverses
        pending_rays.push_back(ray_item(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                                        0, 0, 0, CMAX, CMAX, CMAX));
        pending_rays.push_back(ray_item(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
                                        CMIN, CMIN, CMIN, 0, 0, 0));
        // fractional values, negative products round toward zero
        pending_rays.push_back(ray_item(-3*ONE + 12345, 7, -9,
                                        32'sh0000_8000, -32'sh0001_8001, 32'sh0003_0001,
                                        -ONE - 3, -2*ONE + 5, -ONE + 1,
                                        ONE + 17, 2*ONE - 1, 3*ONE));
        // whole-item extremes and bit patterns
        pending_rays.push_back(rbs_item_t'({12{32'h0000_0000}}));
        pending_rays.push_back(rbs_item_t'({12{32'h7FFF_FFFF}}));
        pending_rays.push_back(rbs_item_t'({12{32'h8000_0000}}));
        pending_rays.push_back(rbs_item_t'({12{32'hFFFF_FFFF}}));
        pending_rays.push_back(rbs_item_t'({12{32'h5555_5555}}));
        pending_rays.push_back(rbs_item_t'({12{32'hAAAA_AAAA}}));

        // Sender pause: wait for the directed set to drain completely
        while (pending_rays.size() != 0 || item_valid)
            @(posedge clk);
        while (owed_hits.size() != 0)
            @(negedge clk);
        @(posedge clk);

        // Mostly well-formed scenes, the rest raw and corner-value noise
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: pending_rays.push_back(aimed_ray(1'b0));
                10, 11, 12:                   pending_rays.push_back(aimed_ray(1'b1));
                13, 14, 15, 16:               pending_rays.push_back(edgy_ray(1'b1));
                default:                      pending_rays.push_back(edgy_ray(1'b0));
            endcase
        end

        while (pending_rays.size() != 0 || item_valid)
            @(posedge clk);
        while (owed_hits.size() != 0)
            @(negedge clk);
        // pipeline is 6 deep; catch any stray result
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("tb_ray_box_slab_intersect OK");
        else
            $display("tb_ray_box_slab_intersect NOT OK");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (~1.2k rays, 29% idle on
    // both sides, one long receiver hold-off)
    initial
    begin
        #2_000_000;
        $display("tb_ray_box_slab_intersect NOT OK");
        $finish;
    end

endmodule
